@@ rtl/core/skt_pkg.sv @@
// Shared types, codes and constants for the sorted key table.
`default_nettype none

package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int LVL_W           = 16;
    localparam int KEY_W           = 32;
    localparam int CNT_OUT_W       = 8;
    localparam logic [LVL_W-1:0] MAX_LEVEL_RST = 16'd100;

    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_SHIFT   = 2'd2;
    localparam logic [1:0] OP_COMPACT = 2'd3;

    // cell commands
    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_HOLD        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SEARCH = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_GOOD   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_EMPTY  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PASS        = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INSERT      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SHIFT       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MARK        = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SWEEP       = 4'd8;

    typedef struct packed {
        logic             vld;
        logic [LVL_W-1:0] lvl;
        logic [KEY_W-1:0] key;
    } ent_t;

    // prefix record: flag seen in window, and the first flagged entry's payload
    typedef struct packed {
        logic flg;
        ent_t ent;
    } pfx_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [LVL_W-1:0] lv;
        logic [KEY_W-1:0] nk;
        logic [LVL_W-1:0] amt;
        logic [LVL_W-1:0] max_lvl;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/skt_cell.sv @@
// One table slot: entry storage plus a prefix-search stage.
`default_nettype none

module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int PASSES = 1,
    parameter int PW     = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctl_t     ctl,
    input  wire logic [PW-1:0] pass,
    input  wire ent_t          left_ent,
    input  wire ent_t          right_ent,
    input  wire logic          left_pf,
    input  wire pfx_t          far_pfx [PASSES],
    output ent_t               ent,
    output pfx_t               pfx
);

    logic             vld_reg, vld_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             flg_reg, flg_next;
    ent_t             pent_reg, pent_next;

    ent_t own;
    pfx_t sel;
    logic good;

    assign own = '{vld: vld_reg, lvl: lvl_reg, key: key_reg};
    assign ent = own;
    assign pfx = '{flg: flg_reg, ent: pent_reg};

    always_comb
    begin
        vld_next  = vld_reg;
        lvl_next  = lvl_reg;
        key_next  = key_reg;
        flg_next  = flg_reg;
        pent_next = pent_reg;
        sel       = far_pfx[pass];
        good      = vld_reg && (key_reg != '0) && (lvl_reg <= ctl.max_lvl);
        case (ctl.cmd)
            CMD_LOAD_SEARCH:
            begin
                flg_next  = !vld_reg || (lvl_reg >= ctl.lv);
                pent_next = own;
            end
            CMD_LOAD_GOOD:
            begin
                flg_next  = good;
                pent_next = own;
            end
            CMD_LOAD_EMPTY:
            begin
                // payload carries the slot index for the count search
                flg_next  = !vld_reg;
                pent_next = '{vld: 1'b0, lvl: LVL_W'(IDX), key: '0};
            end
            CMD_PASS:
            begin
                if (sel.flg)
                begin
                    flg_next  = 1'b1;
                    pent_next = sel.ent;
                end
            end
            CMD_INSERT:
            begin
                if (left_pf)
                begin
                    vld_next = left_ent.vld;
                    lvl_next = left_ent.lvl;
                    key_next = left_ent.key;
                end
                else if (flg_reg)
                begin
                    vld_next = 1'b1;
                    lvl_next = ctl.lv;
                    key_next = ctl.nk;
                end
            end
            CMD_SHIFT:
            begin
                if (flg_reg && vld_reg)
                    lvl_next = lvl_reg + ctl.amt;
            end
            CMD_MARK:
            begin
                // zero level survives only as the first kept entry
                vld_next = good && ((lvl_reg != '0) || !left_pf);
            end
            CMD_SWEEP:
            begin
                if (!vld_reg)
                begin
                    if (right_ent.vld)
                    begin
                        vld_next = 1'b1;
                        lvl_next = right_ent.lvl;
                        key_next = right_ent.key;
                    end
                end
                else if (!left_ent.vld)
                begin
                    vld_next = 1'b0;
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            flg_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            flg_reg <= flg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        key_reg  <= key_next;
        pent_reg <= pent_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// Sorted (level, key) table built as a chain of slot cells with a sequencer.
// Lookup, insert and shift load a search, run the doubling prefix search and then apply the result.
// Compact searches for good entries, marks, sweeps the gaps closed, then searches for the first empty slot.
// One word at a time is taken, only while the sequencer is idle; a new word waits until the last is done.
// The prefix search doubles its distance on each pass, one distance per cycle.
// Reset empties every slot, clears the entry count and sets the level limit to 100.
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // level limit register
    input  wire logic                 cfg_wr_en,
    input  wire logic [LVL_W-1:0]     cfg_wr_data,
    // request words
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [LVL_W-1:0]     level,
    input  wire logic [KEY_W-1:0]     new_key,
    input  wire logic [LVL_W-1:0]     shift_amount,
    // result words
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [KEY_W-1:0]          key,
    output logic                      found,
    output logic                      status,
    output logic [CNT_OUT_W-1:0]      entry_count
);

    localparam int PASSES = $clog2(TABLE_DEPTH);
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int SWW    = $clog2(2 * TABLE_DEPTH);
    localparam logic [PW-1:0]  LAST_PASS  = PW'(PASSES - 1);
    localparam logic [SWW-1:0] LAST_SWEEP = SWW'(2 * TABLE_DEPTH - 1);
    localparam logic [CW-1:0]  FULL_CNT   = CW'(TABLE_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_CLOAD = 3'd4;
    localparam logic [2:0] ST_CSCAN = 3'd5;
    localparam logic [2:0] ST_CDONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [PW-1:0]    pass_reg, pass_next;
    logic [SWW-1:0]   sweep_reg, sweep_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [LVL_W-1:0] max_level_reg;

    // latched request word
    logic [1:0]       op_reg;
    logic [LVL_W-1:0] lv_reg;
    logic [KEY_W-1:0] nk_reg;
    logic [LVL_W-1:0] amt_reg;

    // result register
    logic                 out_valid_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 found_reg;
    logic                 status_reg;
    logic [CNT_OUT_W-1:0] entry_count_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             hit;
    logic             full;
    logic [KEY_W-1:0] res_key;
    logic             res_found;
    logic             res_status;
    logic [CW+CNT_OUT_W-1:0] cnt_wide;

    cell_ctl_t ctl;
    logic [CMD_W-1:0] cmd;
    pfx_t last;

    ent_t ent_o [TABLE_DEPTH];
    pfx_t pfx_o [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_vec;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign key         = key_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    // after the search the last cell holds the first flagged slot of the whole row
    assign last = pfx_o[TABLE_DEPTH-1];
    assign hit  = last.flg && last.ent.vld && (last.ent.lvl == lv_reg);
    assign full = (count_reg == FULL_CNT);

    // the load command is issued in the accept cycle, so it sees the port level
    assign ctl = '{cmd: cmd,
                   lv: (state_reg == ST_IDLE) ? level : lv_reg,
                   nk: nk_reg,
                   amt: amt_reg,
                   max_lvl: max_level_reg};

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        sweep_next = sweep_reg;
        count_next = count_reg;
        cmd        = CMD_HOLD;
        out_load   = 1'b0;
        res_key    = '0;
        res_found  = 1'b0;
        res_status = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd        = (operation == OP_COMPACT) ? CMD_LOAD_GOOD : CMD_LOAD_SEARCH;
                    pass_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd = CMD_PASS;
                if (pass_reg == LAST_PASS)
                    state_next = ST_APPLY;
                else
                    pass_next = pass_reg + 1'b1;
            end
            ST_APPLY:
            begin
                if (op_reg == OP_COMPACT)
                begin
                    // drop marks, then close the gaps
                    cmd        = CMD_MARK;
                    sweep_next = '0;
                    state_next = ST_SWEEP;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            res_key   = hit ? last.ent.key : '0;
                            res_found = hit;
                        end
                        OP_INSERT:
                        begin
                            if (hit)
                            begin
                                res_key   = last.ent.key;
                                res_found = 1'b1;
                            end
                            else if (full)
                            begin
                                res_status = 1'b1;
                            end
                            else
                            begin
                                cmd        = CMD_INSERT;
                                res_key    = nk_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_SHIFT:
                        begin
                            cmd = CMD_SHIFT;
                        end
                        default:
                        begin
                            cmd = CMD_HOLD;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd = CMD_SWEEP;
                if (sweep_reg == LAST_SWEEP)
                    state_next = ST_CLOAD;
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_CLOAD:
            begin
                // new count is the index of the first empty slot
                cmd        = CMD_LOAD_EMPTY;
                pass_next  = '0;
                state_next = ST_CSCAN;
            end
            ST_CSCAN:
            begin
                cmd = CMD_PASS;
                if (pass_reg == LAST_PASS)
                    state_next = ST_CDONE;
                else
                    pass_next = pass_reg + 1'b1;
            end
            ST_CDONE:
            begin
                if (out_free)
                begin
                    count_next = last.flg ? last.ent.lvl[CW-1:0] : FULL_CNT;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_wide = (CW + CNT_OUT_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            sweep_reg     <= '0;
            count_reg     <= '0;
            max_level_reg <= MAX_LEVEL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            sweep_reg <= sweep_next;
            count_reg <= count_next;
            if (cfg_wr_en)
                max_level_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            lv_reg  <= level;
            nk_reg  <= new_key;
            amt_reg <= shift_amount;
        end
        if (out_load)
        begin
            key_reg         <= res_key;
            found_reg       <= res_found;
            status_reg      <= res_status;
            entry_count_reg <= cnt_wide[CNT_OUT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ent_t lft;
        ent_t rgt;
        logic lpf;
        pfx_t far [PASSES];

        if (i == 0)
        begin : g_first
            // slot 0 never pulls from the left and never moves left
            assign lft = '{vld: 1'b1, lvl: '0, key: '0};
            assign lpf = 1'b0;
        end
        else
        begin : g_mid
            assign lft = ent_o[i-1];
            assign lpf = pfx_o[i-1].flg;
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_end
            assign rgt = '0;
        end
        else
        begin : g_inner
            assign rgt = ent_o[i+1];
        end

        for (genvar k = 0; k < PASSES; k++)
        begin : g_far
            if (i >= (1 << k))
            begin : g_src
                assign far[k] = pfx_o[i - (1 << k)];
            end
            else
            begin : g_none
                assign far[k] = '0;
            end
        end

        skt_cell #(
            .IDX    (i),
            .PASSES (PASSES),
            .PW     (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .pass      (pass_reg),
            .left_ent  (lft),
            .right_ent (rgt),
            .left_pf   (lpf),
            .far_pfx   (far),
            .ent       (ent_o[i]),
            .pfx       (pfx_o[i])
        );

        assign vld_vec[i] = ent_o[i].vld;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table depth");

    a_idle_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (((vld_vec + 1'b1) & vld_vec) == '0))
        else $error("occupied slots not packed from slot 0");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(vld_vec) == count_reg))
        else $error("entry count disagrees with occupied slots");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_INSERT) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not add one entry");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_CSCAN)) |-> (pass_reg <= LAST_PASS))
        else $error("search pass out of range");

endmodule

`default_nettype wire
